FILE: rtl/core/izcl_pkg.sv
`timescale 1ns / 1ps
// Package for the interpolated zero-crossing locator.
// Holds the sequencer state type, control bundle, register codes and reset values.
// Has no dependencies.
package izcl_pkg;

  localparam int WINDOW_WIDTH    = 10;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_FIRST = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_LAST  = 2'd1;

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_FIRST_RESET = 10'd10;
  localparam logic [WINDOW_WIDTH-1:0] WINDOW_LAST_RESET  = 10'd1011;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP,
    ST_ACCUM,
    ST_SETUP,
    ST_MEAN_RISE,
    ST_MEAN_FALL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_item;
    logic div_run;
    logic div_done;
    logic load_rise;
    logic load_fall;
    logic accum;
    logic out_load;
  } ctl_t;

endpackage

FILE: rtl/core/interpolated_zero_crossing_locator.sv
`timescale 1ns / 1ps
// Interpolated zero-crossing locator: top level with sequencer and shared divider.
// Depends on izcl_pkg for the state type, control bundle and register codes.
//
// Usage: samples of one column enter on the in channel (sample, last), one
// item per handshake, starting at index 0. Crossings between neighbors whose
// lower index lies in [window_first, window_last] are located by linear
// interpolation and averaged per direction. The item that carries last
// produces one result on the out channel: mean rising and falling positions
// with FRACTION_BITS fraction bits and a found flag for each direction.
// Flow: after an item without a crossing the block is ready for the next item;
// an item with a crossing holds the input while the bit-serial restoring divider
// interpolates it. The last item adds the two mean divisions, which run on the
// same divider with SUM_W = 2 * clog2(MAX_LENGTH) + FRACTION_BITS quotient bits.
// The result sits in an output register; the block goes on taking items of
// the next column while it waits, and only stalls before writing the next
// result if the receiver has not yet taken the previous one.
// The cfg channel is always ready; writes are meant for idle periods only.
// Reset restores the window registers to 10 and 1011 and clears the column.
module interpolated_zero_crossing_locator
  import izcl_pkg::*;
#(
  parameter int MAX_LENGTH    = 1024,
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]            sample,
  input  logic                                      last,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [$clog2(MAX_LENGTH)+FRACTION_BITS-1:0] rising_position,
  output logic [$clog2(MAX_LENGTH)+FRACTION_BITS-1:0] falling_position,
  output logic                                      rising_found,
  output logic                                      falling_found,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]                cfg_index,
  input  logic [WINDOW_WIDTH-1:0]                   cfg_data
);

  localparam int LOW_W   = $clog2(MAX_LENGTH);
  localparam int IDX_W   = $clog2(MAX_LENGTH + 1);
  localparam int POS_W   = LOW_W + FRACTION_BITS;
  localparam int COUNT_W = LOW_W;
  localparam int SUM_W   = POS_W + COUNT_W;
  localparam int V_W     = (COUNT_W > SAMPLE_WIDTH + 1) ? COUNT_W : SAMPLE_WIDTH + 1;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int CMP_W   = (LOW_W > WINDOW_WIDTH) ? LOW_W : WINDOW_WIDTH;

  state_t state;
  state_t state_next;
  ctl_t   ctl;

  logic [WINDOW_WIDTH-1:0] window_first;
  logic [WINDOW_WIDTH-1:0] window_last;

  logic [SAMPLE_WIDTH-1:0] previous_sample;
  logic [IDX_W-1:0]        sample_index;
  logic [SUM_W-1:0]        rising_sum;
  logic [SUM_W-1:0]        falling_sum;
  logic [COUNT_W-1:0]      rising_count;
  logic [COUNT_W-1:0]      falling_count;

  logic [LOW_W-1:0] lower;
  logic             is_last;
  logic             is_rising;

  logic [V_W-1:0]    rem;
  logic [V_W-1:0]    dvs;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  quo;
  logic [STEP_W-1:0] step_count;
  logic [POS_W-1:0]  rise_mean;

  logic [IDX_W-1:0]        idx_m1;
  logic [LOW_W-1:0]        lower_now;
  logic                    pair_ok;
  logic                    rise_hit;
  logic                    fall_hit;
  logic [SAMPLE_WIDTH:0]   prev_ext;
  logic [SAMPLE_WIDTH:0]   cur_ext;
  logic [SAMPLE_WIDTH:0]   num_sel;
  logic [SAMPLE_WIDTH:0]   den_sel;
  logic [V_W:0]            trial;
  logic [V_W:0]            diff;
  logic                    ge;
  logic [POS_W-1:0]        position;

  // Pair examination at the moment an item is taken.
  always_comb begin
    idx_m1    = sample_index - IDX_W'(1);
    lower_now = idx_m1[LOW_W-1:0];
    pair_ok   = (sample_index != '0) && (sample_index < IDX_W'(MAX_LENGTH))
                && (CMP_W'(lower_now) >= CMP_W'(window_first))
                && (CMP_W'(lower_now) <= CMP_W'(window_last));
    rise_hit  = pair_ok && (previous_sample[SAMPLE_WIDTH-1] || previous_sample == '0)
                && !sample[SAMPLE_WIDTH-1] && (sample != '0);
    fall_hit  = pair_ok && !previous_sample[SAMPLE_WIDTH-1] && sample[SAMPLE_WIDTH-1];
    prev_ext  = {previous_sample[SAMPLE_WIDTH-1], previous_sample};
    cur_ext   = {sample[SAMPLE_WIDTH-1], sample};
    if (rise_hit) begin
      num_sel = '0 - prev_ext;
      den_sel = cur_ext - prev_ext;
    end else begin
      num_sel = prev_ext;
      den_sel = prev_ext - cur_ext;
    end
  end

  // Shared restoring divider step.
  always_comb begin
    trial    = {rem, dvd[SUM_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    position = {lower, quo[FRACTION_BITS-1:0]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (rise_hit || fall_hit) begin
            state_next = ST_INTERP;
          end else if (last) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_INTERP: begin
        if (step_count == '0) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = is_last ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        state_next = ST_MEAN_RISE;
      end
      ST_MEAN_RISE: begin
        if (step_count == '0) begin
          state_next = ST_MEAN_FALL;
        end
      end
      ST_MEAN_FALL: begin
        if (step_count == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl           = '0;
    in_ready      = (state == ST_IDLE);
    ctl.take_item = in_valid && (state == ST_IDLE);
    ctl.div_done  = (step_count == '0);
    ctl.div_run   = ((state == ST_INTERP) || (state == ST_MEAN_RISE) || (state == ST_MEAN_FALL))
                    && (step_count != '0);
    ctl.load_rise = (state == ST_SETUP);
    ctl.load_fall = (state == ST_MEAN_RISE) && ctl.div_done;
    ctl.accum     = (state == ST_ACCUM);
    ctl.out_load  = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_first <= WINDOW_FIRST_RESET;
      window_last  <= WINDOW_LAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_FIRST: window_first <= cfg_data;
        CFG_WINDOW_LAST:  window_last  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Column state.
  always_ff @(posedge clk) begin
    if (rst || ctl.out_load) begin
      previous_sample <= '0;
      sample_index    <= '0;
      rising_sum      <= '0;
      falling_sum     <= '0;
      rising_count    <= '0;
      falling_count   <= '0;
    end else begin
      if (ctl.take_item) begin
        previous_sample <= sample;
        if (sample_index < IDX_W'(MAX_LENGTH)) begin
          sample_index <= sample_index + IDX_W'(1);
        end
      end
      if (ctl.accum) begin
        if (is_rising) begin
          rising_sum   <= rising_sum + SUM_W'(position);
          rising_count <= rising_count + COUNT_W'(1);
        end else begin
          falling_sum   <= falling_sum + SUM_W'(position);
          falling_count <= falling_count + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      lower     <= lower_now;
      is_last   <= last;
      is_rising <= rise_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (ctl.take_item && (rise_hit || fall_hit)) begin
      step_count <= STEP_W'(FRACTION_BITS);
    end else if (ctl.load_rise) begin
      step_count <= (rising_count != '0) ? STEP_W'(SUM_W) : '0;
    end else if (ctl.load_fall) begin
      step_count <= (falling_count != '0) ? STEP_W'(SUM_W) : '0;
    end else if (ctl.div_run) begin
      step_count <= step_count - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item && (rise_hit || fall_hit)) begin
      rem <= V_W'(num_sel);
      dvs <= V_W'(den_sel);
      dvd <= '0;
      quo <= '0;
    end else if (ctl.load_rise) begin
      rem <= '0;
      dvs <= V_W'(rising_count);
      dvd <= rising_sum;
      quo <= '0;
    end else if (ctl.load_fall) begin
      rise_mean <= quo[POS_W-1:0];
      rem       <= '0;
      dvs       <= V_W'(falling_count);
      dvd       <= falling_sum;
      quo       <= '0;
    end else if (ctl.div_run) begin
      rem <= ge ? diff[V_W-1:0] : trial[V_W-1:0];
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rising_position  <= rise_mean;
      falling_position <= quo[POS_W-1:0];
      rising_found     <= (rising_count != '0);
      falling_found    <= (falling_count != '0);
    end
  end

  // The interpolation quotient is a pure fraction.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM) |-> (quo[SUM_W-1:FRACTION_BITS] == '0))
    else $error("interpolation fraction overflowed");

  // The partial remainder stays below the divisor while the divider runs.
  assert property (@(posedge clk) disable iff (rst)
    ctl.div_run |-> (rem < dvs))
    else $error("divider remainder out of range");

  // A new result only ever comes from the finishing state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside the finishing state");

  // A direction with no crossing reports position zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rising_found || rising_position == '0)
                   && (falling_found || falling_position == '0)))
    else $error("position reported without a crossing");

endmodule

FILE: tb/interpolated_zero_crossing_locator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for interpolated_zero_crossing_locator: drives sample columns
// and window writes, predicts the mean crossing positions and compares every result.
// Depends on izcl_pkg and the interpolated_zero_crossing_locator RTL.
module interpolated_zero_crossing_locator_tb;
  import izcl_pkg::*;

  localparam int COLUMN_LIMIT  = 1024;
  localparam int FRAC_BITS     = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_LIMIT   = 100000;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

  class crossing_scoreboard;
    typedef struct packed {
      logic [17:0] rise_pos;
      logic [17:0] fall_pos;
      logic        rise_found;
      logic        fall_found;
    } column_means_t;

    logic [WINDOW_WIDTH-1:0] win_first;
    logic [WINDOW_WIDTH-1:0] win_last;
    logic signed [15:0]      prev_sample;
    int unsigned             next_index;
    longint unsigned         rise_sum;
    longint unsigned         fall_sum;
    int unsigned             rise_count;
    int unsigned             fall_count;
    column_means_t           expected_means[$];
    int                      errors;
    int                      samples_seen;
    int                      columns_checked;
    int                      rise_total;
    int                      fall_total;

    function new();
      win_first = WINDOW_FIRST_RESET;
      win_last  = WINDOW_LAST_RESET;
      errors = 0;
      samples_seen = 0;
      columns_checked = 0;
      rise_total = 0;
      fall_total = 0;
      clear_column();
    endfunction

    function void clear_column();
      prev_sample = '0;
      next_index  = 0;
      rise_sum    = 0;
      fall_sum    = 0;
      rise_count  = 0;
      fall_count  = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200)
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [WINDOW_WIDTH-1:0] val);
      if (idx == CFG_WINDOW_FIRST)
        win_first = val;
      else if (idx == CFG_WINDOW_LAST)
        win_last = val;
    endfunction

    function void note_sample(logic signed [15:0] cur, logic is_last);
      longint a;
      longint b;
      int unsigned lower;
      column_means_t m;
      a = prev_sample;
      b = cur;
      samples_seen++;
      if (next_index > 0 && next_index < COLUMN_LIMIT) begin
        lower = next_index - 1;
        if (lower >= win_first && lower <= win_last) begin
          if (a <= 0 && b > 0) begin
            rise_sum += (longint'(lower) << FRAC_BITS) + (((-a) << FRAC_BITS) / (b - a));
            rise_count++;
            rise_total++;
          end
          if (a >= 0 && b < 0) begin
            fall_sum += (longint'(lower) << FRAC_BITS) + ((a << FRAC_BITS) / (a - b));
            fall_count++;
            fall_total++;
          end
        end
      end
      prev_sample = cur;
      if (next_index < COLUMN_LIMIT)
        next_index++;
      if (is_last) begin
        m.rise_pos   = 18'((rise_count != 0) ? rise_sum / rise_count : 0);
        m.fall_pos   = 18'((fall_count != 0) ? fall_sum / fall_count : 0);
        m.rise_found = (rise_count != 0);
        m.fall_found = (fall_count != 0);
        expected_means.push_back(m);
        clear_column();
      end
    endfunction

    task check_means(logic [17:0] rise_pos, logic [17:0] fall_pos,
                     logic rise_found, logic fall_found);
      column_means_t m;
      if (expected_means.size() == 0) begin
        report("result arrived with no column pending");
        return;
      end
      m = expected_means.pop_front();
      columns_checked++;
      if (rise_pos !== m.rise_pos)
        report($sformatf("rising_position got %0d expected %0d", rise_pos, m.rise_pos));
      if (fall_pos !== m.fall_pos)
        report($sformatf("falling_position got %0d expected %0d", fall_pos, m.fall_pos));
      if (rise_found !== m.rise_found)
        report($sformatf("rising_found got %b expected %b", rise_found, m.rise_found));
      if (fall_found !== m.fall_found)
        report($sformatf("falling_found got %b expected %b", fall_found, m.fall_found));
    endtask

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [15:0]         sample = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [17:0]                rising_position;
  logic [17:0]                falling_position;
  logic                       rising_found;
  logic                       falling_found;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [WINDOW_WIDTH-1:0]    cfg_data = '0;

  crossing_scoreboard sb = new();
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   settings_used = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  interpolated_zero_crossing_locator u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample           (sample),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .rising_position  (rising_position),
    .falling_position (falling_position),
    .rising_found     (rising_found),
    .falling_found    (falling_found),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_means(rising_position, falling_position, rising_found, falling_found);
    if (!rst && in_valid && in_ready)
      sb.note_sample(sample, last);
    if (!rst && cfg_valid && cfg_ready)
      sb.set_register(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic signed [15:0] s, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [WINDOW_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_window(input logic [WINDOW_WIDTH-1:0] first,
                                input logic [WINDOW_WIDTH-1:0] final_idx,
                                input logic write_unused);
    write_reg(CFG_WINDOW_FIRST, first);
    write_reg(CFG_WINDOW_LAST, final_idx);
    if (write_unused)
      write_reg(CFG_UNUSED, ~first);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r < 3)
      return 16'($urandom);
    else if (r < 7)
      return 16'(int'($urandom_range(16)) - 8);
    else if (r < 8) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sd32767;
        2: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return 16'(int'($urandom_range(200)) - 100);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0)
      return 1;
    else if (r < 15)
      return $urandom_range(2, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send_column(input int len);
    for (int k = 0; k < len; k++)
      send_sample(pick_sample(), k == len - 1);
  endtask

  task automatic run_phase(input logic [WINDOW_WIDTH-1:0] first,
                           input logic [WINDOW_WIDTH-1:0] final_idx,
                           input int idle_pct, input int stall, input int budget,
                           input logic hold, input logic pause, input logic write_unused);
    int sent;
    int len;
    settle();
    program_window(first, final_idx, write_unused);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    if (hold)
      hold_go <= 1'b1;
    sent = 0;
    while (sent < budget) begin
      len = pick_length();
      send_column(len);
      sent += len;
      if (pause && sent >= budget / 2 && sent - len < budget / 2)
        wait_results();
    end
  endtask

  initial begin : stimulus
    logic signed [15:0] edge_column[9];
    edge_column = '{16'sh8000, 16'sd1, 16'sd32767, 16'sh8000, 16'sd0, 16'sd0,
                    16'sd5, 16'sd0, -16'sd3};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Alternating column under the reset window: only pairs from index 10 on count.
    for (int k = 0; k < 13; k++)
      send_sample(16'((k % 2 != 0) ? 300 + k : -300 - k), k == 12);

    settle();
    program_window(10'd0, 10'd1023, 1'b0);
    for (int k = 0; k < 9; k++)
      send_sample(edge_column[k], k == 8);
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b1);

    run_phase(10'd0, 10'd1023, 0, 0, 50, 1'b1, 1'b0, 1'b0);
    run_phase(10'd0, 10'd1023, 67, 0, 50, 1'b0, 1'b1, 1'b0);
    run_phase(10'd2, 10'd9, 0, 67, 50, 1'b0, 1'b0, 1'b0);
    run_phase(10'd5, 10'd3, 20, 20, 50, 1'b0, 1'b0, 1'b1);
    run_phase(10'd1023, 10'd1023, 0, 0, 25, 1'b0, 1'b0, 1'b0);
    run_phase(10'd0, 10'd0, 20, 20, 25, 1'b0, 1'b0, 1'b0);
    run_phase(10'($urandom_range(20)), 10'($urandom_range(40)), 0, 0, 50,
              1'b0, 1'b0, 1'b0);
    run_phase(10'($urandom_range(20)), 10'($urandom_range(40)), 20, 20, 50,
              1'b0, 1'b0, 1'b0);
    run_phase(10'd1, 10'd1022, 67, 67, 50, 1'b0, 1'b0, 1'b0);

    settle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d samples in %0d checked columns over %0d window settings.",
             sb.samples_seen, sb.columns_checked, settings_used);
    $display("Counted %0d rising and %0d falling crossings, with idling and a long hold-off.",
             sb.rise_total, sb.fall_total);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
